### rtl/core/tmem_pkg.sv
// ----------------------------------------------------------------------------
// tmem_pkg: shared types and constants of the TDMA team membership block
// Item layouts, agent state codes, register indexes and the cell control group.
// ----------------------------------------------------------------------------
package tmem_pkg;

  localparam logic [1:0] ST_NOT_RUNNING = 2'd0;
  localparam logic [1:0] ST_RUNNING     = 2'd1;
  localparam logic [1:0] ST_INSERT      = 2'd2;
  localparam logic [1:0] ST_REMOVE      = 2'd3;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic CFG_OWN_AGENT    = 1'b0;
  localparam logic CFG_REMOVE_LIMIT = 1'b1;

  localparam logic [2:0] OWN_AGENT_RESET    = 3'd0;
  localparam logic [3:0] REMOVE_LIMIT_RESET = 4'd10;

  typedef struct packed {
    logic       operation;
    logic [2:0] source_agent;
  } in_item_t;

  typedef struct packed {
    logic [15:0] member_states;
    logic [3:0]  running_count;
    logic [2:0]  own_slot;
    logic        self_ignored;
  } out_item_t;

  typedef struct packed {
    logic       index;
    logic [3:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic       tick;
    logic       rx;
    logic [2:0] src_agent;
    logic [2:0] own_agent;
    logic [3:0] remove_limit;
  } cell_ctrl_t;

endpackage

### rtl/core/tmem_stream_if.sv
// ----------------------------------------------------------------------------
// tmem_stream_if: valid/ready channel
// Carries one item of the given payload type per accepted handshake.
// ----------------------------------------------------------------------------
interface tmem_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/tdma_team_membership_top.sv
// ----------------------------------------------------------------------------
// tdma_team_membership_top: team membership for round-based TDMA
// A row of per-agent cells tracks membership; a count wave along the row
// assigns slot numbers after each round tick.
//
//   Channel  Role   Payload
//   in       sink   operation, source_agent
//   out      source member_states, running_count, own_slot, self_ignored
//   cfg      sink   index (own_agent, remove_limit), value
//
// A receive item's result is registered in the cycle after its acceptance.
// A tick item updates all cells together, then the slot count wave walks the
// row one cell a cycle; its result is registered as the wave leaves the row.
// Reset is synchronous; the result register holds until taken, and a new item
// is accepted while that result is taken in the same cycle.
// ----------------------------------------------------------------------------
module tdma_team_membership_top #(
  parameter int TEAM_SIZE = 8
) (
  input logic                                clk,
  input logic                                rst,
  tmem_stream_if.sink                        in,
  tmem_stream_if.source                      out,
  tmem_stream_if.sink                        cfg
);
  import tmem_pkg::*;

  localparam int CW = $clog2(TEAM_SIZE + 1);

  localparam logic PH_IDLE  = 1'b0;
  localparam logic PH_SWEEP = 1'b1;

  logic            phase;
  logic            start;
  logic [2:0]      own_agent;
  logic [3:0]      remove_limit;
  logic [3:0]      member_count;
  logic [2:0]      slot_of_self;
  logic            in_fire;
  in_item_t        item;
  cell_ctrl_t      ctrl;
  logic [15:0]     packed_states;
  logic [3:0]      count_sat;
  logic [2:0]      pos_sat;
  logic [1:0]      cell_state [TEAM_SIZE];
  logic            wave [TEAM_SIZE+1];
  logic [CW-1:0]   cnt  [TEAM_SIZE+1];
  logic [CW-1:0]   pos  [TEAM_SIZE+1];

  assign item      = in.payload;
  assign in.ready  = (phase == PH_IDLE) && (!out.valid || out.ready);
  assign in_fire   = in.valid && in.ready;
  assign cfg.ready = 1'b1;

  assign ctrl.tick         = in_fire && (item.operation == OP_TICK);
  assign ctrl.rx           = in_fire && (item.operation == OP_RECEIVE);
  assign ctrl.src_agent    = item.source_agent;
  assign ctrl.own_agent    = own_agent;
  assign ctrl.remove_limit = remove_limit;

  assign wave[0] = start;
  assign cnt[0]  = '0;
  assign pos[0]  = '0;

  for (genvar k = 0; k < TEAM_SIZE; k++) begin : g_cell
    tmem_cell #(.IDX(k), .CW(CW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wave_in  (wave[k]),
      .cnt_in   (cnt[k]),
      .pos_in   (pos[k]),
      .state    (cell_state[k]),
      .wave_out (wave[k+1]),
      .cnt_out  (cnt[k+1]),
      .pos_out  (pos[k+1])
    );
  end

  for (genvar k = 0; k < 8; k++) begin : g_pack
    if (k < TEAM_SIZE) begin : g_live
      assign packed_states[2*k +: 2] =
        (32'(own_agent) == k) ? ST_RUNNING : cell_state[k];
    end else begin : g_none
      assign packed_states[2*k +: 2] = ST_NOT_RUNNING;
    end
  end

  assign count_sat = (32'(cnt[TEAM_SIZE]) > 32'd15) ? 4'd15 : 4'(cnt[TEAM_SIZE]);
  assign pos_sat   = (32'(pos[TEAM_SIZE]) > 32'd7) ? 3'd7 : 3'(pos[TEAM_SIZE]);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_agent    <= OWN_AGENT_RESET;
      remove_limit <= REMOVE_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        CFG_OWN_AGENT:    own_agent    <= cfg.payload.value[2:0];
        CFG_REMOVE_LIMIT: remove_limit <= cfg.payload.value;
        default:          own_agent    <= own_agent;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      start        <= 1'b0;
      out.valid    <= 1'b0;
      member_count <= 4'd1;
      slot_of_self <= 3'd0;
    end else begin
      start <= ctrl.tick;
      if (ctrl.tick) begin
        phase <= PH_SWEEP;
      end else if (wave[TEAM_SIZE]) begin
        phase        <= PH_IDLE;
        member_count <= count_sat;
        slot_of_self <= pos_sat;
      end
      if (ctrl.rx || wave[TEAM_SIZE]) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rx) begin
      out.payload.member_states <= packed_states;
      out.payload.running_count <= member_count;
      out.payload.own_slot      <= slot_of_self;
      out.payload.self_ignored  <= (item.source_agent == own_agent);
    end else if (wave[TEAM_SIZE]) begin
      out.payload.member_states <= packed_states;
      out.payload.running_count <= count_sat;
      out.payload.own_slot      <= pos_sat;
      out.payload.self_ignored  <= 1'b0;
    end
  end

endmodule

### rtl/core/tmem_cell.sv
// ----------------------------------------------------------------------------
// tmem_cell: membership cell for one agent
// Holds the agent's state, heard mark and silent round counter, and passes the
// slot count wave on to the next cell.
// ----------------------------------------------------------------------------
module tmem_cell #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  tmem_pkg::cell_ctrl_t ctrl,
  input  logic                wave_in,
  input  logic [CW-1:0]       cnt_in,
  input  logic [CW-1:0]       pos_in,
  output logic [1:0]          state,
  output logic                wave_out,
  output logic [CW-1:0]       cnt_out,
  output logic [CW-1:0]       pos_out
);
  import tmem_pkg::*;

  logic [1:0] state_next;
  logic       heard;
  logic       heard_next;
  logic [3:0] silent;
  logic [3:0] silent_next;
  logic [3:0] silent_inc;
  logic       is_own;
  logic       is_src;
  logic       member;

  assign is_own     = (32'(ctrl.own_agent) == IDX);
  assign is_src     = (32'(ctrl.src_agent) == IDX);
  assign silent_inc = silent + 4'd1;
  assign member     = (state == ST_RUNNING) || (state == ST_REMOVE);

  always_comb begin
    state_next  = state;
    heard_next  = heard;
    silent_next = silent;
    if (ctrl.tick) begin
      heard_next = 1'b0;
      if (is_own) begin
        state_next = ST_RUNNING;
      end else begin
        unique case (state)
          ST_NOT_RUNNING: begin
            if (heard) state_next = ST_INSERT;
          end
          ST_INSERT: begin
            state_next = heard ? ST_RUNNING : ST_NOT_RUNNING;
          end
          ST_RUNNING: begin
            if (!heard) state_next = ST_REMOVE;
          end
          default: begin
            if (heard) begin
              silent_next = 4'd0;
              state_next  = ST_RUNNING;
            end else if (silent_inc >= ctrl.remove_limit) begin
              silent_next = 4'd0;
              state_next  = ST_NOT_RUNNING;
            end else begin
              silent_next = silent_inc;
            end
          end
        endcase
      end
    end else if (ctrl.rx && is_src && !is_own) begin
      heard_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_NOT_RUNNING;
      heard    <= 1'b0;
      silent   <= 4'd0;
      wave_out <= 1'b0;
    end else begin
      state    <= state_next;
      heard    <= heard_next;
      silent   <= silent_next;
      wave_out <= wave_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wave_in) begin
      cnt_out <= cnt_in + CW'(member);
      pos_out <= is_own ? cnt_in : pos_in;
    end
  end

endmodule
